@@ rtl/core/stag_pkg.sv @@
// Shared types and constants for the sky texel address generator.
// No dependencies; every other file of the block imports this package.
package stag_pkg;

	// payload field widths
	localparam int CA_W       = 13;
	localparam int WALL_W     = 16;
	localparam int ROW_W      = 10;
	localparam int TILE_IDX_W = 4;
	localparam int OFFS_W     = 16;
	localparam int YEND_W     = 11;

	// register widths
	localparam int VA_W   = 12;
	localparam int TC_W   = 5;
	localparam int BITS_W = 4;
	localparam int SH_W   = 11;
	localparam int HF_W   = 24;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// tile size limits
	localparam int SIZE_BITS_MAX = 8;
	localparam int SH_MAX        = 1024;

	// texel column across all tiles: below tiles * 2^SIZE_BITS_MAX
	localparam int XTEX_W = TC_W + SIZE_BITS_MAX;
	// row scaled by tile height
	localparam int DIVIDEND_W = ROW_W + SIZE_BITS_MAX;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEW_ANGLE    = 3'd0,
		REG_TILE_COUNT    = 3'd1,
		REG_WIDTH_BITS    = 3'd2,
		REG_HEIGHT_BITS   = 3'd3,
		REG_SKY_HEIGHT    = 3'd4,
		REG_HEIGHT_FACTOR = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CA_W-1:0] column_angle;
		logic [WALL_W-1:0]      wall_height;
		logic [ROW_W-1:0]       row;
	} req_t;

	typedef struct packed {
		logic                  visible;
		logic [TILE_IDX_W-1:0] tile_index;
		logic [OFFS_W-1:0]     texel_offset;
		logic [YEND_W-1:0]     column_end;
	} rsp_t;

	// configuration after range clamping
	typedef struct packed {
		logic [VA_W-1:0]   view_angle;
		logic [TC_W-1:0]   tiles;
		logic [BITS_W-1:0] width_bits;
		logic [BITS_W-1:0] height_bits;
		logic [SH_W-1:0]   sky_height;
		logic [HF_W-1:0]   height_factor;
	} eff_cfg_t;

endpackage

@@ rtl/core/stag_cfg.sv @@
// Configuration registers of the sky texel address generator, with range clamps.
// Depends on stag_pkg.
module stag_cfg #(
	parameter int MAX_TILES = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [stag_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [stag_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output stag_pkg::eff_cfg_t                 eff
);
	import stag_pkg::*;

	logic [VA_W-1:0]   view_angle_q;
	logic [TC_W-1:0]   tile_count_q;
	logic [BITS_W-1:0] width_bits_q;
	logic [BITS_W-1:0] height_bits_q;
	logic [SH_W-1:0]   sky_height_q;
	logic [HF_W-1:0]   height_factor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_angle_q    <= '0;
			tile_count_q    <= TC_W'(1);
			width_bits_q    <= BITS_W'(6);
			height_bits_q   <= BITS_W'(6);
			sky_height_q    <= SH_W'(100);
			height_factor_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_VIEW_ANGLE:    view_angle_q    <= cfg_wdata[VA_W-1:0];
				REG_TILE_COUNT:    tile_count_q    <= cfg_wdata[TC_W-1:0];
				REG_WIDTH_BITS:    width_bits_q    <= cfg_wdata[BITS_W-1:0];
				REG_HEIGHT_BITS:   height_bits_q   <= cfg_wdata[BITS_W-1:0];
				REG_SKY_HEIGHT:    sky_height_q    <= cfg_wdata[SH_W-1:0];
				REG_HEIGHT_FACTOR: height_factor_q <= cfg_wdata[HF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff.view_angle    = view_angle_q;
		eff.height_factor = height_factor_q;

		priority if (tile_count_q == '0)
			eff.tiles = TC_W'(1);
		else if (32'(tile_count_q) > MAX_TILES)
			eff.tiles = TC_W'(MAX_TILES);
		else
			eff.tiles = tile_count_q;

		eff.width_bits  = (32'(width_bits_q) > SIZE_BITS_MAX) ?
			BITS_W'(SIZE_BITS_MAX) : width_bits_q;
		eff.height_bits = (32'(height_bits_q) > SIZE_BITS_MAX) ?
			BITS_W'(SIZE_BITS_MAX) : height_bits_q;

		priority if (sky_height_q == '0)
			eff.sky_height = SH_W'(1);
		else if (32'(sky_height_q) > SH_MAX)
			eff.sky_height = SH_W'(SH_MAX);
		else
			eff.sky_height = sky_height_q;
	end

endmodule

@@ rtl/core/stag_divider.sv @@
// Pipelined restoring divider with a register after each stage, several bits per stage.
// Depends on stag_pkg only through the import convention; fully generic.
module stag_divider #(
	parameter int DIVIDEND_W = 18,
	parameter int DIVISOR_W  = 11,
	parameter int STAGES     = 3
) (
	input  logic                  clk,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0] quotient
);
	import stag_pkg::*;

	localparam int PER   = (DIVIDEND_W + STAGES - 1) / STAGES;
	localparam int WORKW = PER * STAGES;

	// work register shifts dividend bits out at the top, quotient bits in at the bottom
	logic [WORKW-1:0]     work_in  [STAGES];
	logic [DIVISOR_W-1:0] rem_in   [STAGES];
	logic [WORKW-1:0]     work_nx  [STAGES];
	logic [DIVISOR_W-1:0] rem_nx   [STAGES];
	logic [WORKW-1:0]     work_r   [STAGES];
	logic [DIVISOR_W-1:0] rem_r    [STAGES];

	assign work_in[0] = WORKW'(dividend);
	assign rem_in[0]  = '0;

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		if (g > 0) begin : g_link
			assign work_in[g] = work_r[g-1];
			assign rem_in[g]  = rem_r[g-1];
		end

		always_comb begin
			logic [WORKW-1:0]     wk;
			logic [DIVISOR_W-1:0] rm;
			logic [DIVISOR_W:0]   tr;
			wk = work_in[g];
			rm = rem_in[g];
			for (int i = 0; i < PER; i++) begin
				tr = {rm, wk[WORKW-1]};
				wk = {wk[WORKW-2:0], 1'b0};
				if (tr >= {1'b0, divisor}) begin
					tr    = tr - {1'b0, divisor};
					wk[0] = 1'b1;
				end
				rm = tr[DIVISOR_W-1:0];
			end
			work_nx[g] = wk;
			rem_nx[g]  = rm;
		end

		always_ff @(posedge clk) begin
			work_r[g] <= work_nx[g];
			rem_r[g]  <= rem_nx[g];
		end
	end

	assign quotient = work_r[STAGES-1][DIVIDEND_W-1:0];

endmodule

@@ rtl/core/stag_tile_map.sv @@
// Angle to texel column across all sky tiles: (ang * tiles << wb) / FINE_ANGLES.
// Four register stages; reciprocal multiply plus one correction step. Depends on stag_pkg.
module stag_tile_map #(
	parameter int FINE_ANGLES = 3600
) (
	input  logic                                   clk,
	input  logic [$clog2(FINE_ANGLES)-1:0]         ang_s1,
	input  logic [stag_pkg::TC_W-1:0]              tiles,
	input  logic [stag_pkg::BITS_W-1:0]            width_bits,
	output logic [stag_pkg::XTEX_W-1:0]            xtex_s5
);
	import stag_pkg::*;

	localparam int ANG_W = $clog2(FINE_ANGLES);
	// numerator width: ang * tiles * 2^SIZE_BITS_MAX
	localparam int NW = ANG_W + TC_W + SIZE_BITS_MAX;
	// floor(2^NW / FINE_ANGLES): the estimate is low by at most one
	localparam longint RECIP = (longint'(1) << NW) / FINE_ANGLES;
	localparam int MW = $clog2(RECIP + 1);
	localparam logic [MW-1:0] RECIP_V = MW'(RECIP);
	localparam logic [NW-1:0] FA_N    = NW'(FINE_ANGLES);

	logic [NW-1:0]     n_s2, n_s3, n_s4;
	logic [NW+MW-1:0]  est;
	logic [XTEX_W-1:0] q0_s3, q0_s4;
	logic [NW-1:0]     qd_s4;
	logic [NW-1:0]     rem;

	assign est = NW'(n_s2) * RECIP_V;
	assign rem = n_s4 - qd_s4;

	always_ff @(posedge clk) begin
		n_s2  <= NW'(NW'(ang_s1) * NW'(tiles)) << width_bits;
		q0_s3 <= XTEX_W'(est >> NW);
		n_s3  <= n_s2;
		qd_s4 <= NW'(q0_s3) * FA_N;
		q0_s4 <= q0_s3;
		n_s4  <= n_s3;
		xtex_s5 <= (rem >= FA_N) ? q0_s4 + XTEX_W'(1) : q0_s4;
	end

endmodule

@@ rtl/core/sky_texel_address_generator_core.sv @@
// Sky texel address generator: top level, six register stages at fixed latency.
// Depends on stag_pkg, stag_cfg, stag_divider, stag_tile_map.
//
// One sky pixel request goes in per clock: an item is taken at every edge
// with start high (busy is tied low; the pipeline never stalls). Its result
// shows on rsp with done high for exactly one cycle, after stages s1 to s5 and the
// output register, in request order. The receiver cannot hold it off, so it
// must capture the result at the sixth edge. Sustained rate is one item per
// clock. The latency is set by the texel column path (angle multiply,
// reciprocal multiply, correction) and by the three-stage row/sky_height
// divider running beside it.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once
// and must only be made while no item is in flight.
module sky_texel_address_generator_core #(
	parameter int FINE_ANGLES = 3600,
	parameter int FRAC_BITS   = 16,
	parameter int MAX_TILES   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  stag_pkg::req_t                   req,
	output logic                             done,
	output stag_pkg::rsp_t                   rsp,
	input  logic                             cfg_we,
	input  logic [stag_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [stag_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import stag_pkg::*;

	localparam int ANG_W  = $clog2(FINE_ANGLES);
	// signed sum of column offset and view angle, room for +-FINE_ANGLES
	localparam int SUM_W  = (ANG_W + 2 > 14) ? ANG_W + 2 : 14;
	localparam int DROP_W = WALL_W + HF_W - FRAC_BITS;
	localparam logic signed [SUM_W-1:0] FA_S = SUM_W'(FINE_ANGLES);

	eff_cfg_t eff;

	stag_cfg #(
		.MAX_TILES(MAX_TILES)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.eff       (eff)
	);

	// pipeline never backs up
	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// ---- angle wrap (single wrap, then saturate) ----
	logic signed [SUM_W-1:0] ang_sum;
	logic signed [SUM_W-1:0] ang_wrap;
	logic [ANG_W-1:0]        ang_in;

	always_comb begin
		ang_sum = SUM_W'(req.column_angle) + SUM_W'(signed'({1'b0, eff.view_angle}));
		priority if (ang_sum < 0)
			ang_wrap = ang_sum + FA_S;
		else if (ang_sum >= FA_S)
			ang_wrap = ang_sum - FA_S;
		else
			ang_wrap = ang_sum;

		priority if (ang_wrap < 0)
			ang_in = '0;
		else if (ang_wrap >= FA_S)
			ang_in = ANG_W'(FINE_ANGLES - 1);
		else
			ang_in = ANG_W'(ang_wrap);
	end

	// ---- valid chain ----
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			done_q <= v_s5;
		end
	end

	// ---- payload stages ----
	logic [ANG_W-1:0]  ang_s1;
	logic [WALL_W-1:0] wall_s1;
	logic [ROW_W-1:0]  row_s1, row_s2;
	logic [DROP_W-1:0] drop_s2;
	logic [YEND_W-1:0] yend_s3, yend_s4, yend_s5;
	logic              vis_s3, vis_s4, vis_s5;
	logic [OFFS_W-1:0] quot_s5;

	logic [WALL_W+HF_W-1:0]  wall_prod;
	logic                    sky_gone;
	logic [YEND_W-1:0]       yend_nx;
	logic [DIVIDEND_W-1:0]   quot_s4;
	logic [XTEX_W-1:0]       xtex_s5;

	assign wall_prod = (WALL_W + HF_W)'(wall_s1) * (WALL_W + HF_W)'(eff.height_factor);

	// sky ends where the wall starts; saturate at row zero
	assign sky_gone = drop_s2 >= DROP_W'(eff.sky_height);
	assign yend_nx  = sky_gone ? '0 : eff.sky_height - drop_s2[YEND_W-1:0];

	always_ff @(posedge clk) begin
		ang_s1  <= ang_in;
		wall_s1 <= req.wall_height;
		row_s1  <= req.row;

		drop_s2 <= DROP_W'(wall_prod >> FRAC_BITS);
		row_s2  <= row_s1;

		yend_s3 <= yend_nx;
		vis_s3  <= YEND_W'(row_s2) < yend_nx;

		yend_s4 <= yend_s3;
		vis_s4  <= vis_s3;

		yend_s5 <= yend_s4;
		vis_s5  <= vis_s4;
		quot_s5 <= quot_s4[OFFS_W-1:0];
	end

	// row * tile height / sky_height, result lines up with stage 4
	stag_divider #(
		.DIVIDEND_W(DIVIDEND_W),
		.DIVISOR_W (SH_W),
		.STAGES    (3)
	) u_div (
		.clk      (clk),
		.dividend (DIVIDEND_W'(row_s1) << eff.height_bits),
		.divisor  (eff.sky_height),
		.quotient (quot_s4)
	);

	// texel column across the whole sky strip, lines up with stage 5
	stag_tile_map #(
		.FINE_ANGLES(FINE_ANGLES)
	) u_tile (
		.clk        (clk),
		.ang_s1     (ang_s1),
		.tiles      (eff.tiles),
		.width_bits (eff.width_bits),
		.xtex_s5    (xtex_s5)
	);

	// ---- final stage: tile select, reversed column, offset ----
	logic [XTEX_W-1:0]        tile_raw, tile_max, tile_sel;
	logic [SIZE_BITS_MAX:0]   wfull;
	logic [SIZE_BITS_MAX-1:0] wmask, xrev;
	logic [OFFS_W-1:0]        base;
	rsp_t                     rsp_nx;
	rsp_t                     rsp_q;

	always_comb begin
		tile_raw = xtex_s5 >> eff.width_bits;
		tile_max = XTEX_W'(eff.tiles) - XTEX_W'(1);
		tile_sel = (tile_raw > tile_max) ? tile_max : tile_raw;

		// columns run right to left inside a tile
		wfull = (SIZE_BITS_MAX + 1)'(1) << eff.width_bits;
		wmask = SIZE_BITS_MAX'(wfull - (SIZE_BITS_MAX + 1)'(1));
		xrev  = ~xtex_s5[SIZE_BITS_MAX-1:0] & wmask;
		base  = OFFS_W'(xrev) << eff.height_bits;

		rsp_nx.visible      = vis_s5;
		rsp_nx.tile_index   = TILE_IDX_W'(tile_max - tile_sel);
		rsp_nx.texel_offset = vis_s5 ? base + quot_s5 : '0;
		rsp_nx.column_end   = yend_s5;
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_nx;
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

@@ sim/sky_texel_address_generator_core_test.sv @@
// Self-checking testbench for sky_texel_address_generator_core: a directed set, then random
// sky pixel requests over many register settings, each result checked against a predictor.
// Depends on stag_pkg and the sky texel address generator RTL only.
`timescale 1ns / 100ps

module sky_texel_address_generator_core_test;
	import stag_pkg::*;

	// block parameters, kept equal to the instance below
	localparam int FINE_ANGLES = 3600;
	localparam int FRAC_BITS   = 16;
	localparam int MAX_TILES   = 16;

	localparam int PIPE_LATENCY    = 5;    // cycles from accept to done
	localparam int RAND_PHASES     = 11;
	localparam int ITEMS_PER_PHASE = 85;
	localparam int STALL_LIMIT     = 1000; // cycles with no traffic at all
	localparam int MAX_REPORTS     = 10;

	// Texel predictor plus store of expected results. The register copy is updated
	// at the same edge as the block's, so a request sees the same settings in both.
	class texel_scoreboard;
		logic [VA_W-1:0]   view_angle;
		logic [TC_W-1:0]   tile_count;
		logic [BITS_W-1:0] width_bits;
		logic [BITS_W-1:0] height_bits;
		logic [SH_W-1:0]   sky_height;
		logic [HF_W-1:0]   height_factor;
		rsp_t              expected_texels[$];
		int                mismatch_count;

		function new();
			view_angle     = '0;
			tile_count     = 1;
			width_bits     = 6;
			height_bits    = 6;
			sky_height     = 100;
			height_factor  = '0;
			mismatch_count = 0;
		endfunction

		// only the low bits of the write data land in each register
		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_VIEW_ANGLE:    view_angle    = data[VA_W-1:0];
				REG_TILE_COUNT:    tile_count    = data[TC_W-1:0];
				REG_WIDTH_BITS:    width_bits    = data[BITS_W-1:0];
				REG_HEIGHT_BITS:   height_bits   = data[BITS_W-1:0];
				REG_SKY_HEIGHT:    sky_height    = data[SH_W-1:0];
				REG_HEIGHT_FACTOR: height_factor = data[HF_W-1:0];
				default: ;
			endcase
		endfunction

		function rsp_t predict_texel(req_t r);
			longint ang, tiles, wb, hb, sh, w, h;
			longint xtex, tile, drop, yend, offs;
			rsp_t   e;
			// single wrap into the circle, anything still outside is pinned to the ends
			ang = longint'($signed(r.column_angle)) + longint'(view_angle);
			if (ang < 0)
				ang += FINE_ANGLES;
			else if (ang >= FINE_ANGLES)
				ang -= FINE_ANGLES;
			if (ang < 0)
				ang = 0;
			else if (ang >= FINE_ANGLES)
				ang = FINE_ANGLES - 1;
			// register values out of range are clamped
			tiles = (tile_count == 0) ? 1 : longint'(tile_count);
			if (tiles > MAX_TILES)
				tiles = MAX_TILES;
			wb = (width_bits > SIZE_BITS_MAX) ? SIZE_BITS_MAX : longint'(width_bits);
			hb = (height_bits > SIZE_BITS_MAX) ? SIZE_BITS_MAX : longint'(height_bits);
			sh = (sky_height == 0) ? 1 : longint'(sky_height);
			if (sh > SH_MAX)
				sh = SH_MAX;
			w = longint'(1) << wb;
			h = longint'(1) << hb;
			// texel column over the whole sky strip, tiles counted in reverse
			xtex = ang * tiles * w / FINE_ANGLES;
			tile = xtex >> wb;
			if (tile > tiles - 1)
				tile = tiles - 1;
			// sky ends where the projected wall starts
			drop = (longint'(r.wall_height) * longint'(height_factor)) >> FRAC_BITS;
			yend = (drop >= sh) ? 0 : sh - drop;
			e.visible    = longint'(r.row) < yend;
			e.tile_index = TILE_IDX_W'(tiles - 1 - tile);
			offs = 0;
			if (e.visible)
				offs = h * (w - 1) - ((xtex & (w - 1)) << hb) + longint'(r.row) * h / sh;
			e.texel_offset = OFFS_W'(offs);
			e.column_end   = YEND_W'(yend);
			return e;
		endfunction

		function void note_request(req_t r);
			expected_texels.push_back(predict_texel(r));
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_texels.size() == 0) begin
				if (mismatch_count < MAX_REPORTS)
					$display("texel result with nothing pending: vis=%0d tile=%0d offs=%0d end=%0d",
						got.visible, got.tile_index, got.texel_offset, got.column_end);
				mismatch_count++;
				return;
			end
			want = expected_texels.pop_front();
			if (got.visible !== want.visible || got.tile_index !== want.tile_index ||
					got.texel_offset !== want.texel_offset ||
					got.column_end !== want.column_end) begin
				if (mismatch_count < MAX_REPORTS)
					$display("texel mismatch: exp vis=%0d tile=%0d offs=%0d end=%0d, %s%0d %s%0d %s%0d %s%0d",
						want.visible, want.tile_index, want.texel_offset, want.column_end,
						"got vis=", got.visible, "tile=", got.tile_index,
						"offs=", got.texel_offset, "end=", got.column_end);
				mismatch_count++;
			end
		endfunction

		function int pending();
			return expected_texels.size();
		endfunction
	endclass

	// every input has a known value from time zero
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	req_t                  req       = '0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  busy;
	logic                  done;
	rsp_t                  rsp;

	texel_scoreboard sb;
	int              idle_cycles = 0;

	sky_texel_address_generator_core #(
		.FINE_ANGLES(FINE_ANGLES),
		.FRAC_BITS  (FRAC_BITS),
		.MAX_TILES  (MAX_TILES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Results cannot be held off: capture every done cycle at the edge ending it.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(rsp);
	end

	// Watchdog: any accepted item, result or register write counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Hold the item on req with start high until an edge sees busy low.
	// Called and returns at a rising edge; start is left high for back-to-back items.
	task automatic send_item(req_t r);
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(r);
	endtask

	// Stop sending and wait for every outstanding result; the block is then idle.
	task automatic drain();
		if (start)
			start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg_port(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// cfg_we stays high across the six writes and drops once afterwards
	task automatic program_config(logic [CFG_DATA_W-1:0] va, tc, wb, hb, sh, hf);
		write_reg_port(REG_VIEW_ANGLE, va);
		write_reg_port(REG_TILE_COUNT, tc);
		write_reg_port(REG_WIDTH_BITS, wb);
		write_reg_port(REG_HEIGHT_BITS, hb);
		write_reg_port(REG_SKY_HEIGHT, sh);
		write_reg_port(REG_HEIGHT_FACTOR, hf);
		cfg_we <= 1'b0;
	endtask

	// mostly in-range settings; sometimes out of range, sometimes junk above the field
	function automatic logic [CFG_DATA_W-1:0] junk_above(int unsigned v, int fw);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'(v);
		if ($urandom_range(0, 7) == 0)
			d = d | (CFG_DATA_W'($urandom) << fw);
		return d;
	endfunction

	task automatic random_config();
		int unsigned va, tc, wb, hb, sh, hf;
		va = ($urandom_range(0, 4) == 0) ? $urandom_range(3600, 4095) : $urandom_range(0, 3599);
		tc = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
		wb = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 8);
		hb = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 8);
		sh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
		case ($urandom_range(0, 3))
			0:       hf = 0;
			1:       hf = $urandom_range(0, 1 << 16);
			2:       hf = $urandom_range(0, 1 << 20);
			default: hf = $urandom & 24'hFFFFFF;
		endcase
		program_config(junk_above(va, VA_W), junk_above(tc, TC_W), junk_above(wb, BITS_W),
			junk_above(hb, BITS_W), junk_above(sh, SH_W), CFG_DATA_W'(hf));
	endtask

	function automatic req_t make_req(int ca, int wall, int row);
		req_t r;
		r.column_angle = CA_W'(ca);
		r.wall_height  = WALL_W'(wall);
		r.row          = ROW_W'(row);
		return r;
	endfunction

	// Rows are biased below the sky height so visible pixels show up often;
	// walls lean small so a nonzero height factor still leaves some sky.
	function automatic req_t random_req();
		int ca, wall, row, ceil;
		ca = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 8191) - 4096
			: $urandom_range(0, 7199) - 3600;
		case ($urandom_range(0, 3))
			0:       wall = $urandom_range(0, 65535);
			1, 2:    wall = $urandom_range(0, 255);
			default: wall = ($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(0, 1);
		endcase
		ceil = (sb.sky_height == 0) ? 1 : int'(sb.sky_height);
		if (ceil > 1023)
			ceil = 1023;
		row = ($urandom_range(0, 1) == 0) ? $urandom_range(0, ceil) : $urandom_range(0, 1023);
		return make_req(ca, wall, row);
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// After each item: now and then let the pipeline run dry, otherwise a random gap if gaps are on.
	task automatic pace(bit gaps_on);
		int gap;
		if ($urandom_range(0, 99) == 0)
			drain();
		else if (gaps_on) begin
			gap = pick_gap();
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_directed(int ca, int wall, int row);
		send_item(make_req(ca, wall, row));
		pace(1'b1);
	endtask

	initial begin
		bit gaps_on;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: height factor 0 so the sky ends at row 100 everywhere.
		// Angle extremes of the field, sky boundary rows, wall extremes.
		send_directed(0, 0, 0);
		send_directed(-4096, 0, 99);
		send_directed(4095, 0, 100);
		send_directed(-3600, 65535, 0);
		send_directed(3599, 0, 1023);
		send_directed(-1, 0, 50);
		send_directed(1, 0, 0);

		// View angle past the circle so the wrapped sum can stay too high; tile count 0,
		// size bits above 8 and sky height 0 all clamp.
		drain();
		program_config(4095, 0, 15, 15, 0, 0);
		send_directed(4095, 0, 0);
		send_directed(-4096, 65535, 0);
		send_directed(0, 0, 1);

		// Sum still negative after one wrap; tile count above the limit; sky height
		// above 1024; full height factor pushing most columns out of view.
		drain();
		program_config(0, 31, 0, 8, 2047, 24'hFFFFFF);
		send_directed(-4096, 0, 0);
		send_directed(-3601, 0, 5);
		send_directed(3599, 0, 1023);
		send_directed(0, 1, 0);
		send_directed(100, 65535, 0);

		// Largest in-range tiles and sky; drop equals the wall height.
		drain();
		program_config(3599, 16, 8, 0, 1024, 24'h010000);
		send_directed(1, 0, 0);
		send_directed(0, 1024, 0);
		send_directed(4095, 1023, 0);
		send_directed(4095, 1023, 1);
		send_directed(-3600, 0, 1023);

		// Random phases; first and last use the extremes of the in-range settings.
		// Every third phase runs without gaps.
		for (int p = 0; p < RAND_PHASES; p++) begin
			drain();
			if (p == 0)
				program_config(3599, 16, 8, 8, 1024, 24'hFFFFFF);
			else if (p == RAND_PHASES - 1)
				program_config(0, 1, 0, 0, 1, 0);
			else
				random_config();
			gaps_on = (p % 3 != 1);
			repeat (ITEMS_PER_PHASE) begin
				send_item(random_req());
				pace(gaps_on);
			end
		end

		// Everything sent: collect the tail, then watch a few more cycles for strays.
		drain();
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/stag_pkg.sv
rtl/core/stag_cfg.sv
rtl/core/stag_divider.sv
rtl/core/stag_tile_map.sv
rtl/core/sky_texel_address_generator_core.sv
sim/sky_texel_address_generator_core_test.sv
